// ===== rtl/core/matrix3x3_inverse_top_assert.svh =====
// Assertion macros for the 3x3 matrix inverse checker.
`ifndef MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3X3_INVERSE_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define M3INV_ALWAYS(label, expr) label: assert property (@(posedge clock) \
   disable iff (reset) (expr)) else $error("m3inv: check failed");

// Implication checked outside reset.
`define M3INV_IMPLY(label, ante, cons) label: assert property (@(posedge clock) \
   disable iff (reset) (ante) |-> (cons)) else $error("m3inv: check failed");

`endif

// ===== rtl/core/m3inv_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse.
package m3inv_pkg;

   localparam int ElemWidth    = 32;
   localparam int ThrWidth     = 31;
   localparam int NumElem      = 9;
   localparam int ProdWidth    = 2 * ElemWidth;
   localparam int MinorWidth   = 2 * ElemWidth + 1;
   localparam int DetWidth     = 3 * ElemWidth + 3;
   localparam int MinorLatency = 2;
   localparam int DetLatency   = 4;
   localparam int DivLatency   = ElemWidth + 4;
   localparam int TotalLatency = MinorLatency + DetLatency + DivLatency + 1;

   typedef logic [3:0] elem_idx_type;

   // element indexes of a*b - c*d for each adjugate entry, row-major
   localparam elem_idx_type MinorIdx [NumElem][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd1, 4'd8, 4'd2, 4'd7}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd3, 4'd8, 4'd5, 4'd6}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd0, 4'd5, 4'd2, 4'd3},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd0, 4'd7, 4'd1, 4'd6}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef logic signed [ElemWidth-1:0]  elem_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [MinorWidth-1:0] minor_type;
   typedef logic signed [DetWidth-1:0]   det_type;
   typedef logic [DetWidth-1:0]          det_mag_type;
   typedef logic [ThrWidth-1:0]          thr_type;

   typedef elem_type  matrix_type    [NumElem];
   typedef minor_type minor_set_type [NumElem];

   typedef struct packed {
      det_mag_type det_mag;
      logic        det_neg;
      logic        singular;
   } det_info_type;

   typedef struct packed {
      elem_type in_r0c0;
      elem_type in_r0c1;
      elem_type in_r0c2;
      elem_type in_r1c0;
      elem_type in_r1c1;
      elem_type in_r1c2;
      elem_type in_r2c0;
      elem_type in_r2c1;
      elem_type in_r2c2;
   } req_word_type;

   typedef struct packed {
      elem_type out_r0c0;
      elem_type out_r0c1;
      elem_type out_r0c2;
      elem_type out_r1c0;
      elem_type out_r1c1;
      elem_type out_r1c2;
      elem_type out_r2c0;
      elem_type out_r2c1;
      elem_type out_r2c2;
      logic     singular;
      logic     overflow;
   } rsp_word_type;

endpackage

// ===== rtl/core/matrix3x3_inverse_top.sv =====
// 3x3 matrix inverse: a matrix passes from start to rsp_valid through a pipeline (2 minor stages,
// 4 determinant stages, 36 divider stages of which 32 form one quotient bit each, 1 output).
// Throughput one matrix per cycle; busy stays low and results cannot be held off.
// Synchronous active-high reset clears all valid bits; det_threshold resets to 1.
// Configuration writes are taken every cycle (csr_ready high).
module matrix3x3_inverse_top import m3inv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  thr_type      csr_data
);

   thr_type              thr_ff;
   matrix_type           req_mat;
   logic                 mn_valid;
   matrix_type           mn_mat;
   minor_set_type        mn_minor;
   logic                 dt_valid;
   matrix_type           dt_mat;
   minor_set_type        dt_minor;
   det_info_type         dt_info;
   logic [NumElem-1:0]   div_valid;
   logic [NumElem-1:0]   div_sat;
   matrix_type           div_elem;
   matrix_type           dl_mat_ff  [DivLatency];
   logic                 dl_sing_ff [DivLatency];
   matrix_type           out_mat;
   logic                 out_sing;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_in, rsp_word_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrWidth'(1);
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   assign req_mat[0] = req_word.in_r0c0;
   assign req_mat[1] = req_word.in_r0c1;
   assign req_mat[2] = req_word.in_r0c2;
   assign req_mat[3] = req_word.in_r1c0;
   assign req_mat[4] = req_word.in_r1c1;
   assign req_mat[5] = req_word.in_r1c2;
   assign req_mat[6] = req_word.in_r2c0;
   assign req_mat[7] = req_word.in_r2c1;
   assign req_mat[8] = req_word.in_r2c2;

   m3inv_minor u_minor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_mat    (req_mat),
      .out_valid (mn_valid),
      .out_mat   (mn_mat),
      .out_minor (mn_minor)
   );

   m3inv_det #(.FRAC_BITS(FRAC_BITS)) u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mn_valid),
      .in_mat    (mn_mat),
      .in_minor  (mn_minor),
      .thr       (thr_ff),
      .out_valid (dt_valid),
      .out_mat   (dt_mat),
      .out_minor (dt_minor),
      .out_info  (dt_info)
   );

   for (genvar k = 0; k < NumElem; k++) begin : g_div
      m3inv_div #(.FRAC_BITS(FRAC_BITS), .FLIP(1'(k % 2))) u_div (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (dt_valid),
         .in_minor   (dt_minor[k]),
         .in_det_mag (dt_info.det_mag),
         .in_det_neg (dt_info.det_neg),
         .out_valid  (div_valid[k]),
         .out_elem   (div_elem[k]),
         .out_sat    (div_sat[k])
      );
   end

   // input matrix and singular flag ride alongside the dividers
   always_ff @(posedge clock) begin
      dl_mat_ff[0]  <= dt_mat;
      dl_sing_ff[0] <= dt_info.singular;
      for (int s = 1; s < DivLatency; s++) begin
         dl_mat_ff[s]  <= dl_mat_ff[s-1];
         dl_sing_ff[s] <= dl_sing_ff[s-1];
      end
   end

   always_comb begin
      out_sing = dl_sing_ff[DivLatency-1];
      out_mat  = out_sing ? dl_mat_ff[DivLatency-1] : div_elem;
      rsp_word_in.out_r0c0 = out_mat[0];
      rsp_word_in.out_r0c1 = out_mat[1];
      rsp_word_in.out_r0c2 = out_mat[2];
      rsp_word_in.out_r1c0 = out_mat[3];
      rsp_word_in.out_r1c1 = out_mat[4];
      rsp_word_in.out_r1c2 = out_mat[5];
      rsp_word_in.out_r2c0 = out_mat[6];
      rsp_word_in.out_r2c1 = out_mat[7];
      rsp_word_in.out_r2c2 = out_mat[8];
      rsp_word_in.singular = out_sing;
      rsp_word_in.overflow = !out_sing && (|div_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= &div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/core/m3inv_minor.sv =====
// Two-stage pipeline forming the nine 2x2 minors of the adjugate.
module m3inv_minor import m3inv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  matrix_type    in_mat,
   output logic          out_valid,
   output matrix_type    out_mat,
   output minor_set_type out_minor
);

   logic          v1_ff, v2_ff;
   matrix_type    mat1_ff, mat2_ff;
   prod_type      pa_in [NumElem];
   prod_type      pb_in [NumElem];
   prod_type      pa_ff [NumElem];
   prod_type      pb_ff [NumElem];
   minor_set_type mn_in, mn_ff;

   always_comb begin
      for (int k = 0; k < NumElem; k++) begin
         pa_in[k] = in_mat[MinorIdx[k][0]] * in_mat[MinorIdx[k][1]];
         pb_in[k] = in_mat[MinorIdx[k][2]] * in_mat[MinorIdx[k][3]];
         mn_in[k] = MinorWidth'(pa_ff[k]) - MinorWidth'(pb_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      mat1_ff <= in_mat;
      mat2_ff <= mat1_ff;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      mn_ff   <= mn_in;
   end

   assign out_valid = v2_ff;
   assign out_mat   = mat2_ff;
   assign out_minor = mn_ff;

endmodule

// ===== rtl/core/m3inv_det.sv =====
// Four-stage determinant pipeline with magnitude and singular test.
module m3inv_det import m3inv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  matrix_type    in_mat,
   input  minor_set_type in_minor,
   input  thr_type       thr,
   output logic          out_valid,
   output matrix_type    out_mat,
   output minor_set_type out_minor,
   output det_info_type  out_info
);

   localparam int PartWidth = 2 * ElemWidth + 1;
   localparam int ThrShWidth = ThrWidth + 2 * FRAC_BITS;
   localparam int CmpWidth = (DetWidth > ThrShWidth) ? DetWidth : ThrShWidth;

   logic                        v_ff   [DetLatency];
   matrix_type                  mat_ff [DetLatency];
   minor_set_type               mn_ff  [DetLatency];
   logic signed [PartWidth-1:0] pl_in [3];
   logic signed [PartWidth-1:0] ph_in [3];
   logic signed [PartWidth-1:0] pl_ff [3];
   logic signed [PartWidth-1:0] ph_ff [3];
   det_type                     pr_in [3];
   det_type                     pr_ff [3];
   det_type                     det_in, det_ff;
   det_info_type                info_in, info_ff;
   logic [CmpWidth-1:0]         thr_cmp;

   always_comb begin
      for (int t = 0; t < 3; t++) begin
         pl_in[t] = in_mat[t] * $signed({1'b0, in_minor[3*t][ElemWidth-1:0]});
         ph_in[t] = in_mat[t] * $signed(in_minor[3*t][MinorWidth-1:ElemWidth]);
         pr_in[t] = (DetWidth'(ph_ff[t]) <<< ElemWidth) + DetWidth'(pl_ff[t]);
      end
      det_in = pr_ff[0] - pr_ff[1] + pr_ff[2];
      thr_cmp = CmpWidth'(thr) << (2 * FRAC_BITS);
      info_in.det_neg = det_ff[DetWidth-1];
      info_in.det_mag = info_in.det_neg ? -det_ff : det_ff;
      info_in.singular = (info_in.det_mag == '0) ||
                         (CmpWidth'(info_in.det_mag) < thr_cmp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DetLatency; s++) v_ff[s] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < DetLatency; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      mat_ff[0] <= in_mat;
      mn_ff[0]  <= in_minor;
      for (int s = 1; s < DetLatency; s++) begin
         mat_ff[s] <= mat_ff[s-1];
         mn_ff[s]  <= mn_ff[s-1];
      end
      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
      pr_ff   <= pr_in;
      det_ff  <= det_in;
      info_ff <= info_in;
   end

   assign out_valid = v_ff[DetLatency-1];
   assign out_mat   = mat_ff[DetLatency-1];
   assign out_minor = mn_ff[DetLatency-1];
   assign out_info  = info_ff;

endmodule

// ===== rtl/core/m3inv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, rounding, saturation.
module m3inv_div import m3inv_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter bit FLIP      = 1'b0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  minor_type   in_minor,
   input  det_mag_type in_det_mag,
   input  logic        in_det_neg,
   output logic        out_valid,
   output elem_type    out_elem,
   output logic        out_sat
);

   localparam int W         = ElemWidth;
   localparam int NumWidth  = MinorWidth + 2 * FRAC_BITS;
   localparam int TopWidth  = NumWidth - W;
   localparam int BigWidth  = (TopWidth > DetWidth) ? TopWidth : DetWidth;
   localparam int RemWidth  = DetWidth;

   // prologue
   logic                  v0_ff, neg0_ff;
   logic [MinorWidth-1:0] mag_in, mag0_ff;
   det_mag_type           d0_ff;
   logic [NumWidth-1:0]   num;
   logic [TopWidth-1:0]   num_top;

   // iteration stages
   logic                v_ff    [W+1];
   logic                neg_ff  [W+1];
   logic                big_ff  [W+1];
   det_mag_type         d_ff    [W+1];
   logic [RemWidth-1:0] rem_ff  [W+1];
   logic [RemWidth-1:0] rem_in  [W+1];
   logic [W-1:0]        q_ff    [W+1];
   logic [W-1:0]        q_in    [W+1];
   logic [W-1:0]        nlo_ff  [W+1];
   logic [W-1:0]        nlo_in  [W+1];
   logic                big_in;
   logic [RemWidth:0]   r2;
   logic [RemWidth:0]   r2_sub;
   logic                ge;

   // rounding and output
   logic                vr_ff, negr_ff, bigr_ff;
   logic [W:0]          qr_in, qr_ff;
   logic                inc;
   logic [W:0]          lim;
   logic                sat_in;
   logic [W:0]          qv;
   logic [W:0]          sv;
   logic                vo_ff, sat_ff;
   elem_type            elem_ff;

   always_comb begin
      mag_in  = in_minor[MinorWidth-1] ? -in_minor : in_minor;
      num     = NumWidth'(mag0_ff) << (2 * FRAC_BITS);
      num_top = num[NumWidth-1:W];
      big_in  = BigWidth'(num_top) >= BigWidth'(d0_ff);
      rem_in[0] = RemWidth'(num_top);
      q_in[0]   = '0;
      nlo_in[0] = num[W-1:0];
      r2 = '0;
      r2_sub = '0;
      ge = 1'b0;
      for (int s = 0; s < W; s++) begin
         r2     = {rem_ff[s], nlo_ff[s][W-1]};
         r2_sub = r2 - {1'b0, d_ff[s]};
         ge     = r2 >= {1'b0, d_ff[s]};
         rem_in[s+1] = ge ? r2_sub[RemWidth-1:0] : r2[RemWidth-1:0];
         q_in[s+1]   = {q_ff[s][W-2:0], ge};
         nlo_in[s+1] = nlo_ff[s] << 1;
      end
      inc    = {rem_ff[W], 1'b0} >= {1'b0, d_ff[W]};
      qr_in  = {1'b0, q_ff[W]} + (W+1)'(inc);
      lim    = negr_ff ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
      sat_in = bigr_ff || (qr_ff > lim);
      qv     = sat_in ? lim : qr_ff;
      sv     = negr_ff ? -qv : qv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         for (int s = 0; s <= W; s++) v_ff[s] <= 1'b0;
         vr_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v0_ff   <= in_valid;
         v_ff[0] <= v0_ff;
         for (int s = 1; s <= W; s++) v_ff[s] <= v_ff[s-1];
         vr_ff <= v_ff[W];
         vo_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag0_ff   <= mag_in;
      neg0_ff   <= in_minor[MinorWidth-1] ^ in_det_neg ^ FLIP;
      d0_ff     <= in_det_mag;
      neg_ff[0] <= neg0_ff;
      big_ff[0] <= big_in;
      d_ff[0]   <= d0_ff;
      for (int s = 1; s <= W; s++) begin
         neg_ff[s] <= neg_ff[s-1];
         big_ff[s] <= big_ff[s-1];
         d_ff[s]   <= d_ff[s-1];
      end
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      nlo_ff  <= nlo_in;
      negr_ff <= neg_ff[W];
      bigr_ff <= big_ff[W];
      qr_ff   <= qr_in;
      elem_ff <= sv[W-1:0];
      sat_ff  <= sat_in;
   end

   assign out_valid = vo_ff;
   assign out_elem  = elem_ff;
   assign out_sat   = sat_ff;

endmodule

// ===== rtl/core/m3inv_check.sv =====
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
`include "matrix3x3_inverse_top_assert.svh"
module m3inv_check import m3inv_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_word_type rsp_word,
   input logic         csr_ready
);

   `M3INV_ALWAYS(a_never_busy, !busy)
   `M3INV_ALWAYS(a_csr_ready, csr_ready)
   `M3INV_IMPLY(a_result_follows, start && !busy, ##TotalLatency rsp_valid)
   `M3INV_IMPLY(a_result_has_cause, rsp_valid, $past(start && !busy, TotalLatency))
   `M3INV_IMPLY(a_singular_no_ovf, rsp_valid && rsp_word.singular, !rsp_word.overflow)

endmodule

bind matrix3x3_inverse_top m3inv_check u_m3inv_check (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
`timescale 1ns / 100ps

module tb_top;
   import m3inv_pkg::*;

   localparam int FracBits   = 16;
   localparam int IdleLimit  = 4000;
   localparam int WideWidth  = 256;

   typedef logic signed [WideWidth-1:0] wide_type;
   typedef logic [WideWidth-1:0]        wide_mag_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   thr_type      csr_data;

   rsp_word_type inverse_q[$];
   thr_type      thr_model;
   int           error_count;
   int           sent_count;
   int           got_count;
   int           singular_count;
   int           overflow_count;
   int           idle_cycles;
   int           burst_left;

   matrix3x3_inverse_top #(.FRAC_BITS(FracBits)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_word_type predict_inverse(req_word_type w);
      elem_type     el[NumElem];
      elem_type     res[NumElem];
      wide_type     e[NumElem];
      wide_type     mn[NumElem];
      wide_type     det;
      wide_mag_type adet, thr, am, num, q, r, lim;
      logic         neg, ovf;
      rsp_word_type o;
      el = '{w.in_r0c0, w.in_r0c1, w.in_r0c2, w.in_r1c0, w.in_r1c1, w.in_r1c2,
             w.in_r2c0, w.in_r2c1, w.in_r2c2};
      for (int k = 0; k < NumElem; k++) e[k] = el[k];
      mn[0] = e[4] * e[8] - e[5] * e[7];
      mn[1] = e[1] * e[8] - e[2] * e[7];
      mn[2] = e[1] * e[5] - e[2] * e[4];
      mn[3] = e[3] * e[8] - e[5] * e[6];
      mn[4] = e[0] * e[8] - e[2] * e[6];
      mn[5] = e[0] * e[5] - e[2] * e[3];
      mn[6] = e[3] * e[7] - e[4] * e[6];
      mn[7] = e[0] * e[7] - e[1] * e[6];
      mn[8] = e[0] * e[4] - e[1] * e[3];
      det  = e[0] * mn[0] - e[1] * mn[3] + e[2] * mn[6];
      adet = det < 0 ? -det : det;
      thr  = wide_mag_type'(thr_model) << (2 * FracBits);
      ovf  = 1'b0;
      if (adet == 0 || adet < thr) begin
         res = el;
         o.singular = 1'b1;
      end else begin
         for (int k = 0; k < NumElem; k++) begin
            neg = (mn[k] < 0) != (det < 0);
            if (k % 2 == 1) neg = ~neg;
            am  = mn[k] < 0 ? -mn[k] : mn[k];
            num = am << (2 * FracBits);
            q   = num / adet;
            r   = num % adet;
            if ((r << 1) >= adet) q = q + 1;
            lim = neg ? (wide_mag_type'(1) << 31) : (wide_mag_type'(1) << 31) - 1;
            if (q > lim) begin
               q   = lim;
               ovf = 1'b1;
            end
            res[k] = neg ? elem_type'(-q) : elem_type'(q);
         end
         o.singular = 1'b0;
      end
      o.overflow = ovf;
      o.out_r0c0 = res[0];
      o.out_r0c1 = res[1];
      o.out_r0c2 = res[2];
      o.out_r1c0 = res[3];
      o.out_r1c1 = res[4];
      o.out_r1c2 = res[5];
      o.out_r2c0 = res[6];
      o.out_r2c1 = res[7];
      o.out_r2c2 = res[8];
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("ERROR @%0t result %0d %s: got %h expected %h", $time, got_count, field,
               got, want);
   endtask

   always @(posedge clock) begin
      elem_type     g[NumElem];
      elem_type     x[NumElem];
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (inverse_q.size() == 0) begin
            error_count++;
            $display("ERROR @%0t unexpected result word", $time);
         end else begin
            want = inverse_q.pop_front();
            g = '{rsp_word.out_r0c0, rsp_word.out_r0c1, rsp_word.out_r0c2,
                  rsp_word.out_r1c0, rsp_word.out_r1c1, rsp_word.out_r1c2,
                  rsp_word.out_r2c0, rsp_word.out_r2c1, rsp_word.out_r2c2};
            x = '{want.out_r0c0, want.out_r0c1, want.out_r0c2,
                  want.out_r1c0, want.out_r1c1, want.out_r1c2,
                  want.out_r2c0, want.out_r2c1, want.out_r2c2};
            for (int k = 0; k < NumElem; k++)
               if (g[k] !== x[k])
                  report_mismatch($sformatf("out_r%0dc%0d", k / 3, k % 3), g[k], x[k]);
            if (rsp_word.singular !== want.singular)
               report_mismatch("singular", rsp_word.singular, want.singular);
            if (rsp_word.overflow !== want.overflow)
               report_mismatch("overflow", rsp_word.overflow, want.overflow);
            singular_count += want.singular;
            overflow_count += want.overflow;
         end
         got_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no activity for %0d cycles", IdleLimit);
         $display("matrix3x3_inverse_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(req_word_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      inverse_q.push_back(predict_inverse(w));
      sent_count++;
   endtask

   task automatic send_paced(req_word_type w);
      send_word(w);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 30);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (inverse_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(thr_type v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      thr_model = v;
   endtask

   function automatic req_word_type make_matrix(elem_type a[NumElem]);
      req_word_type w;
      w = '{a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
      return w;
   endfunction

   function automatic elem_type rand_small(int span);
      return elem_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic req_word_type rand_matrix(int mode);
      elem_type a[NumElem];
      for (int k = 0; k < NumElem; k++) begin
         case (mode)
            0: a[k] = rand_small(4 << FracBits);
            1: a[k] = elem_type'($urandom);
            2: a[k] = rand_small(1 << 20);
            default: a[k] = ($urandom_range(0, 1) == 1) ? elem_type'($urandom)
                                                        : rand_small(300);
         endcase
      end
      if (mode == 2) begin
         for (int k = 0; k < 3; k++) a[6 + k] = a[k] + a[3 + k];
         if ($urandom_range(0, 1) == 1) a[$urandom_range(0, 8)] += rand_small(3);
      end
      return make_matrix(a);
   endfunction

   task automatic test_directed;
      elem_type one, a[NumElem];
      one = elem_type'(1 << FracBits);
      a = '{one, 0, 0, 0, one, 0, 0, 0, one};
      send_paced(make_matrix(a));
      a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_paced(make_matrix(a));
      a = '{2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2};
      send_paced(make_matrix(a));
      a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_paced(make_matrix(a));
      a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_paced(make_matrix(a));
      for (int k = 0; k < NumElem; k++) a[k] = 32'sh7fffffff;
      send_paced(make_matrix(a));
      for (int k = 0; k < NumElem; k++) a[k] = 32'sh80000000;
      send_paced(make_matrix(a));
      a = '{32'sh7fffffff, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh7fffffff};
      send_paced(make_matrix(a));
      a = '{0, one, 0, one, 0, 0, 0, 0, one};
      send_paced(make_matrix(a));
      a = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 10 * one};
      send_paced(make_matrix(a));
      a = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one};
      send_paced(make_matrix(a));
      a = '{256, 0, 0, 0, 256, 0, 0, 0, 256};
      send_paced(make_matrix(a));
      a = '{one, 0, 0, 0, one, 0, 0, 0, 1};
      send_paced(make_matrix(a));
      drain();
      write_threshold('0);
      a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_paced(make_matrix(a));
      a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_paced(make_matrix(a));
      drain();
      write_threshold(thr_type'(1 << FracBits));
      a = '{one, 0, 0, 0, one, 0, 0, 0, one};
      send_paced(make_matrix(a));
      a = '{one, 0, 0, 0, one, 0, 0, 0, one - 1};
      send_paced(make_matrix(a));
      drain();
      write_threshold({ThrWidth{1'b1}});
      a = '{32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff};
      send_paced(make_matrix(a));
      a = '{one, 0, 0, 0, one, 0, 0, 0, one};
      send_paced(make_matrix(a));
      drain();
   endtask

   task automatic test_random(thr_type thr, int mode, int count);
      write_threshold(thr);
      for (int n = 0; n < count; n++)
         send_paced(rand_matrix(mode < 0 ? $urandom_range(0, 3) : mode));
      drain();
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_word    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      thr_model   = thr_type'(1);
      error_count = 0;
      sent_count  = 0;
      got_count   = 0;
      singular_count = 0;
      overflow_count = 0;
      idle_cycles = 0;
      burst_left  = 10;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(thr_type'(1), 0, 500);
      test_random('0, 1, 400);
      test_random(thr_type'(1 << FracBits), 2, 300);
      test_random(thr_type'($urandom_range(0, 1 << 20)), -1, 300);
      test_random({ThrWidth{1'b1}}, 1, 150);
      test_random(thr_type'($urandom), -1, 200);
      repeat (TotalLatency + 10) @(posedge clock);
      $display("summary: %0d matrices sent, %0d results checked, %0d singular, %0d saturated",
               sent_count, got_count, singular_count, overflow_count);
      $display("summary: thresholds 0, 1, one unit, maximum and random; %0d mismatches",
               error_count);
      if (error_count == 0 && inverse_q.size() == 0) begin
         $display("matrix3x3_inverse_top test passed");
      end else begin
         $display("matrix3x3_inverse_top test failed");
      end
      $finish;
   end

endmodule

// ===== matrix3x3_inverse_top.f =====
+incdir+rtl/core
rtl/core/m3inv_pkg.sv
rtl/core/m3inv_minor.sv
rtl/core/m3inv_det.sv
rtl/core/m3inv_div.sv
rtl/core/matrix3x3_inverse_top.sv
rtl/core/m3inv_check.sv
tb/sv/tb_top.sv
